[rtl/gbwa_pkg.sv]
`timescale 1ns / 1ps

package gbwa_pkg;

    localparam int RATE_W   = 16;
    localparam int TIME_W   = 32;
    localparam int WLEN_W   = 9;
    localparam int SPAN_W   = 31;
    localparam int SUM_W    = 25;
    localparam int BIAS_W   = 24;
    localparam int FRAC_W   = 8;
    localparam int DIVW     = SUM_W + FRAC_W;
    localparam int DCNT_W   = $clog2(DIVW + 1);
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [WLEN_W-1:0] WLEN_RESET = WLEN_W'(200);
    localparam logic [SPAN_W-1:0] SPAN_RESET = SPAN_W'(20000);

    localparam logic [1:0] ACT_ADD       = 2'd0;
    localparam logic [1:0] ACT_CLR_KEEP  = 2'd1;
    localparam logic [1:0] ACT_CLR_ALL   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPAN      = 1'd1;

    typedef struct packed {
        logic [1:0]               action;
        logic signed [RATE_W-1:0] gyro_rate;
        logic [TIME_W-1:0]        sample_time;
    } t_in_item;

    typedef struct packed {
        logic                     offset_valid;
        logic signed [BIAS_W-1:0] offset_q8;
    } t_out_item;

    typedef struct packed {
        logic capture;
        logic clr_win;
        logic clr_valid;
        logic rd_old;
        logic upd;
        logic rd_time;
        logic div_start;
        logic div_step;
        logic commit;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic fill_eq;
        logic span_ok;
        logic div_last;
        logic out_free;
    } t_sts;

endpackage

[rtl/gbwa_ctrl.sv]
`timescale 1ns / 1ps

module gbwa_ctrl
    import gbwa_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_action,
    input  t_sts       i_sts,
    output logic       o_in_ready,
    output t_cmd       o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RDOLD = 3'd1;
    localparam logic [2:0] S_UPD   = 3'd2;
    localparam logic [2:0] S_RDT   = 3'd3;
    localparam logic [2:0] S_CHK   = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    case (i_action)
                        ACT_ADD: begin
                            n_state = S_RDOLD;
                        end
                        ACT_CLR_KEEP: begin
                            o_cmd.clr_win = 1'b1;
                            n_state       = S_OUT;
                        end
                        ACT_CLR_ALL: begin
                            o_cmd.clr_win   = 1'b1;
                            o_cmd.clr_valid = 1'b1;
                            n_state         = S_OUT;
                        end
                        default: begin
                            n_state = S_OUT;
                        end
                    endcase
                end
            end
            S_RDOLD: begin
                o_cmd.rd_old = 1'b1;
                n_state      = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = S_RDT;
            end
            S_RDT: begin
                o_cmd.rd_time = 1'b1;
                n_state       = S_CHK;
            end
            S_CHK: begin
                if (i_sts.fill_eq && i_sts.span_ok) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    o_cmd.clr_valid = 1'b1;
                    n_state         = S_OUT;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.commit = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[rtl/gbwa_datapath.sv]
`timescale 1ns / 1ps

module gbwa_datapath
    import gbwa_pkg::*;
#(
    parameter int WINDOW_MAX = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  t_in_item              i_in,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out
);

    localparam int IW  = $clog2(WINDOW_MAX);
    localparam int FCW = $clog2(WINDOW_MAX + 1);
    localparam int CW  = (FCW > WLEN_W) ? FCW : WLEN_W;
    localparam int OW  = FCW + 1;

    logic signed [RATE_W-1:0] rate_store [WINDOW_MAX];
    logic [TIME_W-1:0]        time_store [WINDOW_MAX];

    logic [WLEN_W-1:0]        r_wl;
    logic [SPAN_W-1:0]        r_ms;
    logic [IW-1:0]            r_wi;
    logic [FCW-1:0]           r_fc;
    logic signed [SUM_W-1:0]  r_sum;
    logic                     r_valid;
    logic signed [BIAS_W-1:0] r_bias;
    logic signed [RATE_W-1:0] r_rate;
    logic [TIME_W-1:0]        r_t;
    logic signed [RATE_W-1:0] r_old_rate;
    logic [TIME_W-1:0]        r_old_time;
    logic [DIVW-1:0]          r_dq;
    logic [WLEN_W-1:0]        r_rem;
    logic [DCNT_W-1:0]        r_cnt;
    logic                     r_neg;
    logic                     r_out_valid;
    t_out_item                r_out;

    logic [CW-1:0]            wl_ext;
    logic [CW-1:0]            len;
    logic [CW-1:0]            fc_ext;
    logic                     full;
    logic signed [OW-1:0]     old_diff;
    logic [OW-1:0]            old_sum;
    logic [IW-1:0]            oldest;
    logic [IW-1:0]            wi_next;
    logic signed [SUM_W-1:0]  sum_next;
    logic [TIME_W-1:0]        span_d;
    logic [SUM_W-1:0]         mag;
    logic [WLEN_W:0]          rem_sh;
    logic [WLEN_W:0]          rem_sub;
    logic                     q_bit;
    logic [BIAS_W-1:0]        q_lo;

    always_comb begin
        wl_ext = CW'(r_wl);
        if (r_wl == '0) begin
            len = CW'(1);
        end else if (wl_ext > CW'(WINDOW_MAX)) begin
            len = CW'(WINDOW_MAX);
        end else begin
            len = wl_ext;
        end
        fc_ext = CW'(r_fc);
        full   = (fc_ext >= len);

        old_diff = $signed(OW'(r_wi)) - $signed(OW'(r_fc));
        old_sum  = OW'(old_diff) + OW'(WINDOW_MAX);
        oldest   = old_diff[OW-1] ? old_sum[IW-1:0] : old_diff[IW-1:0];
        wi_next  = (r_wi == IW'(WINDOW_MAX - 1)) ? '0 : r_wi + IW'(1);

        sum_next = r_sum + SUM_W'(r_rate) - (full ? SUM_W'(r_old_rate) : '0);

        span_d = r_t - r_old_time;

        mag = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);

        rem_sh  = {r_rem, r_dq[DIVW-1]};
        rem_sub = rem_sh - {1'b0, len[WLEN_W-1:0]};
        q_bit   = (rem_sh >= {1'b0, len[WLEN_W-1:0]});
        q_lo    = r_dq[BIAS_W-1:0];
    end

    assign o_sts.fill_eq  = (fc_ext == len);
    assign o_sts.span_ok  = span_d[TIME_W-1] || (span_d[SPAN_W-1:0] <= r_ms);
    assign o_sts.div_last = (r_cnt == DCNT_W'(DIVW - 1));
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd) begin
            rate_store[r_wi] <= r_rate;
            time_store[r_wi] <= r_t;
        end
        if (i_cmd.rd_old) begin
            r_old_rate <= rate_store[oldest];
        end
        if (i_cmd.rd_time) begin
            r_old_time <= time_store[oldest];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_rate <= i_in.gyro_rate;
            r_t    <= i_in.sample_time;
        end
        if (i_cmd.div_start) begin
            r_dq  <= {mag, FRAC_W'(0)};
            r_rem <= '0;
            r_cnt <= '0;
            r_neg <= r_sum[SUM_W-1];
        end else if (i_cmd.div_step) begin
            r_dq  <= {r_dq[DIVW-2:0], q_bit};
            r_rem <= q_bit ? rem_sub[WLEN_W-1:0] : rem_sh[WLEN_W-1:0];
            r_cnt <= r_cnt + DCNT_W'(1);
        end
        if (i_cmd.out_load) begin
            r_out.offset_valid <= r_valid;
            r_out.offset_q8    <= r_valid ? r_bias : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wl        <= WLEN_RESET;
            r_ms        <= SPAN_RESET;
            r_wi        <= '0;
            r_fc        <= '0;
            r_sum       <= '0;
            r_valid     <= 1'b0;
            r_bias      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_WINDOW_LENGTH: begin
                        r_wl  <= i_cfg_data[WLEN_W-1:0];
                        r_wi  <= '0;
                        r_fc  <= '0;
                        r_sum <= '0;
                    end
                    REG_MAX_SPAN: begin
                        r_ms <= i_cfg_data[SPAN_W-1:0];
                    end
                    default: begin
                        r_ms <= r_ms;
                    end
                endcase
            end
            if (i_cmd.clr_win) begin
                r_wi  <= '0;
                r_fc  <= '0;
                r_sum <= '0;
            end
            if (i_cmd.clr_valid) begin
                r_valid <= 1'b0;
            end
            if (i_cmd.upd) begin
                r_sum <= sum_next;
                r_wi  <= wi_next;
                if (!full) begin
                    r_fc <= r_fc + FCW'(1);
                end
            end
            if (i_cmd.commit) begin
                r_valid <= 1'b1;
                r_bias  <= r_neg ? BIAS_W'(-q_lo) : BIAS_W'(q_lo);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

[rtl/gyro_bias_window_average.sv]
`timescale 1ns / 1ps

// Channel   Signals                              Item
// in        i_in_valid / o_in_ready / i_in       action, gyro_rate, sample_time
// out       o_out_valid / i_out_ready / o_out    offset_valid, offset_q8
// cfg       i_cfg_valid / o_cfg_ready            i_cfg_index, i_cfg_data
//
// An add-sample item that passes its checks goes through ring reads, update and check,
// then the bit-serial Q.8 divide, then commit and load. Clears and action 3 go
// straight to the load, and failed checks go to it from the check. Input is ready
// again the cycle after the load, so a new item is taken only once the last is loaded.
// Reset is synchronous and active low; no clearing pass is needed.
// A result held in the output register holds the next load, and input waits for it.

module gyro_bias_window_average
    import gbwa_pkg::*;
#(
    parameter int WINDOW_MAX = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    gbwa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_in.action),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    gbwa_datapath #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in        (i_in),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;
    import gbwa_pkg::*;

    localparam int          WIN_MAX         = 256;
    localparam int          TAIL_CYCLES     = 50;
    localparam logic [1:0]  ACT_REPORT_ONLY = 2'd3;
    localparam logic [SPAN_W-1:0] SPAN_TOP  = {SPAN_W{1'b1}};

    class bias_tracker;
        logic [WLEN_W-1:0]        win_len;
        logic [SPAN_W-1:0]        span_limit;
        logic signed [RATE_W-1:0] rate_ring [WIN_MAX];
        logic [TIME_W-1:0]        time_ring [WIN_MAX];
        int                       head;
        int                       held;
        int                       rate_sum;
        bit                       est_valid;
        logic signed [BIAS_W-1:0] bias_q8;
        t_out_item                expected_bias [$];
        int                       fail_count;

        function new();
            win_len    = WLEN_RESET;
            span_limit = SPAN_RESET;
            head       = 0;
            held       = 0;
            rate_sum   = 0;
            est_valid  = 1'b0;
            bias_q8    = '0;
            fail_count = 0;
        endfunction

        function int window_size();
            if (win_len == 0) begin
                return 1;
            end
            if (win_len > WIN_MAX) begin
                return WIN_MAX;
            end
            return int'(win_len);
        endfunction

        function void empty_window();
            head     = 0;
            held     = 0;
            rate_sum = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_WINDOW_LENGTH: begin
                    win_len = data[WLEN_W-1:0];
                    empty_window();
                end
                REG_MAX_SPAN: begin
                    span_limit = data[SPAN_W-1:0];
                end
                default: begin
                end
            endcase
        endfunction

        function void add_sample(logic signed [RATE_W-1:0] rate, logic [TIME_W-1:0] stamp);
            int               len;
            int               old;
            logic [TIME_W-1:0] gap_ms;
            len = window_size();
            if (held >= len) begin
                old = (head + WIN_MAX - held) % WIN_MAX;
                rate_sum -= rate_ring[old];
                held--;
            end
            rate_ring[head] = rate;
            time_ring[head] = stamp;
            rate_sum += rate;
            head = (head + 1) % WIN_MAX;
            held++;
            if (held == len) begin
                old = (head + WIN_MAX - held) % WIN_MAX;
                gap_ms = stamp - time_ring[old];
                if (longint'($signed(gap_ms)) <= longint'(span_limit)) begin
                    est_valid = 1'b1;
                    bias_q8 = BIAS_W'((longint'(rate_sum) * 256) / longint'(len));
                    return;
                end
            end
            est_valid = 1'b0;
        endfunction

        function void note_item(t_in_item it);
            t_out_item res;
            case (it.action)
                ACT_ADD: begin
                    add_sample(it.gyro_rate, it.sample_time);
                end
                ACT_CLR_KEEP: begin
                    empty_window();
                end
                ACT_CLR_ALL: begin
                    empty_window();
                    est_valid = 1'b0;
                end
                default: begin
                end
            endcase
            res.offset_valid = est_valid;
            res.offset_q8    = est_valid ? bias_q8 : '0;
            expected_bias.push_back(res);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (expected_bias.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("unexpected item: valid=%0d q8=%0d", got.offset_valid,
                             got.offset_q8);
                end
                return;
            end
            want = expected_bias.pop_front();
            if (got.offset_valid !== want.offset_valid || got.offset_q8 !== want.offset_q8) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("mismatch: expected valid=%0d q8=%0d, got valid=%0d q8=%0d",
                             want.offset_valid, want.offset_q8, got.offset_valid, got.offset_q8);
                end
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in_item              i_in;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_out_item             o_out;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    bias_tracker       tracker = new();
    int                send_calm;
    int                take_calm;
    logic [TIME_W-1:0] clock_ms;

    gyro_bias_window_average dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever begin
            #10 i_clk = ~i_clk;
        end
    end

    initial begin
        #15_000_000;
        $display("[gyro_bias_window_average] ERROR");
        $finish;
    end

    function automatic int draw_wait(ref int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0) begin
            calm = $urandom_range(8, 40);
        end
        return $urandom_range(0, 11);
    endfunction

    function automatic t_in_item make_item(logic [1:0] act, logic signed [RATE_W-1:0] rate,
                                           logic [TIME_W-1:0] stamp);
        t_in_item it;
        it.action      = act;
        it.gyro_rate   = rate;
        it.sample_time = stamp;
        return it;
    endfunction

    task automatic send_item(input t_in_item it);
        int gap;
        gap = draw_wait(send_calm);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= it;
        do @(posedge i_clk); while (!o_in_ready);
        tracker.note_item(it);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.write_reg(idx, data);
    endtask

    task automatic drain(input int limit);
        int waited;
        waited = 0;
        i_in_valid <= 1'b0;
        while (tracker.expected_bias.size() != 0 && waited < limit) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(input int unsigned wl, input logic [SPAN_W-1:0] span);
        drain(4000);
        write_cfg(REG_WINDOW_LENGTH, {23'($urandom), WLEN_W'(wl)});
        write_cfg(REG_MAX_SPAN, {1'($urandom), span});
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input int n_items, input int step_max, input int noise_pct);
        t_in_item it;
        int       k;
        for (k = 0; k < n_items; k++) begin
            if ($urandom_range(0, 99) < noise_pct) begin
                it = make_item(2'($urandom_range(1, 3)), 16'($urandom), $urandom);
            end else begin
                if ($urandom_range(0, 39) == 0) begin
                    clock_ms = $urandom;
                end else begin
                    clock_ms = clock_ms + $urandom_range(0, step_max);
                end
                it = make_item(ACT_ADD, 16'($urandom), clock_ms);
                if ($urandom_range(0, 19) == 0) begin
                    it.gyro_rate = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                end
            end
            send_item(it);
        end
    endtask

    initial begin
        i_out_ready <= 1'b0;
        take_calm = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            int stall;
            stall = draw_wait(take_calm);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            tracker.check_result(o_out);
        end
    end

    initial begin
        int unsigned       wl_plan [14];
        int                n_plan [14];
        int                p;
        int                eff;
        int                step_max;
        logic [SPAN_W-1:0] span;

        wl_plan = '{200, 1, 0, 2, 3, 7, 16, 256, 511, 5, 33, 4, 300, 9};
        n_plan  = '{240, 70, 70, 70, 70, 70, 70, 300, 300, 70, 70, 70, 290, 70};

        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in        <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        send_calm = 0;
        clock_ms  = $urandom;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(make_item(ACT_ADD, 16'sd100, 32'd1000));
        send_item(make_item(ACT_REPORT_ONLY, -16'sd5, 32'd1001));

        configure(2, 31'd10);
        send_item(make_item(ACT_ADD, 16'sh7FFF, 32'd0));
        send_item(make_item(ACT_ADD, 16'sh7FFF, 32'd10));
        send_item(make_item(ACT_ADD, 16'sh8000, 32'd20));
        send_item(make_item(ACT_ADD, 16'sh8000, 32'd31));
        send_item(make_item(ACT_REPORT_ONLY, 16'sh7FFF, 32'hFFFF_FFFF));
        send_item(make_item(ACT_ADD, 16'sh8000, 32'd41));
        send_item(make_item(ACT_REPORT_ONLY, 16'sd0, 32'd0));
        send_item(make_item(ACT_CLR_KEEP, 16'sd7, 32'd50));
        send_item(make_item(ACT_ADD, 16'sd1, 32'hFFFF_FFFF));
        send_item(make_item(ACT_ADD, 16'sd0, 32'd5));
        send_item(make_item(ACT_ADD, -16'sd1, 32'h8000_0010));
        send_item(make_item(ACT_CLR_ALL, 16'sd9, 32'd60));
        send_item(make_item(ACT_ADD, 16'sd5, 32'd100));
        send_item(make_item(ACT_ADD, -16'sd3, 32'd100));

        configure(3, 31'd0);
        send_item(make_item(ACT_ADD, -16'sd1, 32'd7));
        send_item(make_item(ACT_ADD, 16'sd0, 32'd7));
        send_item(make_item(ACT_ADD, 16'sd0, 32'd7));
        send_item(make_item(ACT_ADD, 16'sd0, 32'd8));

        for (p = 0; p < 14; p++) begin
            eff = (wl_plan[p] == 0) ? 1 : ((wl_plan[p] > WIN_MAX) ? WIN_MAX : wl_plan[p]);
            step_max = (p == 0) ? 60 : $urandom_range(0, 24);
            if (p == 0) begin
                span = SPAN_RESET;
            end else if (p == 1) begin
                span = '0;
            end else if (p == 2) begin
                span = SPAN_TOP;
            end else begin
                case ($urandom_range(0, 3))
                    0: span = '0;
                    1: span = SPAN_TOP;
                    2: span = SPAN_W'($urandom_range(0, eff * step_max + 1));
                    default: span = SPAN_W'($urandom);
                endcase
            end
            configure(wl_plan[p], span);
            run_phase(n_plan[p], step_max, (eff <= 16) ? 12 : 1);
        end

        drain(4000);
        if (tracker.expected_bias.size() != 0) begin
            tracker.fail_count++;
        end
        if (tracker.fail_count == 0) begin
            $display("[gyro_bias_window_average] OK");
        end else begin
            $display("[gyro_bias_window_average] ERROR");
        end
        $finish;
    end

endmodule
